[rtl/pdir_pkg.sv]
// Shared types and constants for the pulse-distance IR decoder.
// Used by every module under rtl; no dependencies of its own.
package pdir_pkg;

  localparam int TIME_W     = 24;
  localparam int FRAME_BITS = 32;
  localparam int CNT_W      = $clog2(FRAME_BITS + 1);
  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BITS);

  localparam logic [CFG_DATA_W-1:0] HEADER_THR_RST = CFG_DATA_W'(2000);
  localparam logic [CFG_DATA_W-1:0] ONE_THR_RST    = CFG_DATA_W'(842);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_THR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THR    = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CFG_DATA_W-1:0] header_thr;
    logic [CFG_DATA_W-1:0] one_thr;
  } pdir_cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  bits_collected;
    logic              header_seen;
    logic              frame_done;
    logic [WORD_W-1:0] frame_word;
    logic [WORD_W-1:0] frames_total;
  } pdir_result_t;

endpackage

[rtl/pdir_cfg.sv]
// Configuration registers of the IR decoder: header and one-bit thresholds.
// Depends on pdir_pkg.
module pdir_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pdir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdir_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output pdir_pkg::pdir_cfg_t            cfg_o
);
  import pdir_pkg::*;

  logic [CFG_DATA_W-1:0] header_thr_r;
  logic [CFG_DATA_W-1:0] one_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_thr_r <= HEADER_THR_RST;
      one_thr_r    <= ONE_THR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HEADER_THR: header_thr_r <= cfg_wdata;
        REG_ONE_THR:    one_thr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o.header_thr = header_thr_r;
  assign cfg_o.one_thr    = one_thr_r;

endmodule

[rtl/pdir_decode.sv]
// Frame decoder state and edge classification for one timestamp per cycle while step_en is high.
// Depends on pdir_pkg; the result is the state after the step, unregistered.
module pdir_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [pdir_pkg::TIME_W-1:0] capture_time,
  input  pdir_pkg::pdir_cfg_t        cfg_i,
  output pdir_pkg::pdir_result_t     res_o
);
  import pdir_pkg::*;

  logic                  seen_r,   seen_nxt;
  logic [TIME_W-1:0]     prev_r,   prev_nxt;
  logic                  coll_r,   coll_nxt;
  logic [CNT_W-1:0]      cnt_r,    cnt_nxt;
  logic [FRAME_BITS-1:0] shift_r,  shift_nxt;
  logic [WORD_W-1:0]     last_r,   last_nxt;
  logic [WORD_W-1:0]     frames_r, frames_nxt;

  logic [TIME_W-1:0] delta;
  logic              hdr;
  logic              done;

  always_comb begin
    seen_nxt   = 1'b1;
    prev_nxt   = capture_time;
    coll_nxt   = coll_r;
    cnt_nxt    = cnt_r;
    shift_nxt  = shift_r;
    last_nxt   = last_r;
    frames_nxt = frames_r;
    hdr        = 1'b0;
    done       = 1'b0;
    // Subtraction wraps naturally at the timestamp width.
    delta      = capture_time - prev_r;

    if (seen_r) begin
      if (delta >= cfg_i.header_thr) begin
        hdr       = 1'b1;
        shift_nxt = '0;
        cnt_nxt   = '0;
        coll_nxt  = 1'b1;
      end else if (coll_r && (cnt_r < FRAME_CNT)) begin
        shift_nxt = {shift_r[FRAME_BITS-2:0], (delta >= cfg_i.one_thr)};
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_nxt == FRAME_CNT) begin
          last_nxt   = WORD_W'(shift_nxt);
          frames_nxt = frames_r + WORD_W'(1);
          coll_nxt   = 1'b0;
          done       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= 1'b0;
      prev_r   <= '0;
      coll_r   <= 1'b0;
      cnt_r    <= '0;
      shift_r  <= '0;
      last_r   <= '0;
      frames_r <= '0;
    end else if (step_en) begin
      seen_r   <= seen_nxt;
      prev_r   <= prev_nxt;
      coll_r   <= coll_nxt;
      cnt_r    <= cnt_nxt;
      shift_r  <= shift_nxt;
      last_r   <= last_nxt;
      frames_r <= frames_nxt;
    end
  end

  assign res_o.bits_collected = cnt_nxt;
  assign res_o.header_seen    = hdr;
  assign res_o.frame_done     = done;
  assign res_o.frame_word     = last_nxt;
  assign res_o.frames_total   = frames_nxt;

  a_done_full: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && done |-> cnt_nxt == FRAME_CNT)
    else $error("frame completed without a full bit count");

  a_hdr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(hdr && done))
    else $error("edge both a header and a frame end");

  a_hdr_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && hdr |=> coll_r && (cnt_r == '0))
    else $error("header did not restart the collector");

  a_coll_bound: assert property (@(posedge clk) disable iff (!rst_n)
    coll_r |-> cnt_r < FRAME_CNT)
    else $error("collector active with a full bit count");

endmodule

[rtl/pulse_distance_ir_decoder.sv]
// Pulse-distance (NEC style) IR decoder: each input word is the timestamp of one rising
// edge; each accepted word yields exactly one result word, giving the bit count, header and
// frame-complete flags, the last completed 32-bit frame and the running frame count. An
// accepted word is held in an input register, decoded against the decoder state when the
// output register is free and placed there; one word is taken every cycle while the output
// side keeps up. The user must write thresholds through the cfg_ port while the block is idle;
// the block does not enforce this. Depends on pdir_pkg, pdir_cfg and pdir_decode.
module pulse_distance_ir_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pdir_pkg::TIME_W-1:0]     in_capture_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pdir_pkg::CNT_W-1:0]      out_bits_collected,
  output logic                           out_header_seen,
  output logic                           out_frame_done,
  output logic [pdir_pkg::WORD_W-1:0]     out_frame_word,
  output logic [pdir_pkg::WORD_W-1:0]     out_frames_total,
  input  logic                           cfg_wr_en,
  input  logic [pdir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdir_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pdir_pkg::*;

  pdir_cfg_t    cfg;
  pdir_result_t res;
  pdir_result_t res_r;

  logic              in_valid_r;
  logic [TIME_W-1:0] in_time_r;
  logic              out_valid_r;
  logic              advance;

  // The held word moves on whenever the output register is empty or being emptied.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  pdir_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  pdir_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .capture_time (in_time_r),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_time_r <= in_capture_time;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bits_collected = res_r.bits_collected;
  assign out_header_seen    = res_r.header_seen;
  assign out_frame_done     = res_r.frame_done;
  assign out_frame_word     = res_r.frame_word;
  assign out_frames_total   = res_r.frames_total;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !advance)
    else $error("pending output word overwritten");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_time_r))
    else $error("held input word lost during stall");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("decoded word did not reach the output register");

endmodule
